// ===== src/raycast_sprite_projection_top_defines.svh =====
// Assertion macros for the sprite projection block.
// They expect clk and rst_n in the scope of the use.
`ifndef RAYCAST_SPRITE_PROJECTION_TOP_DEFINES_SVH
`define RAYCAST_SPRITE_PROJECTION_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSP_ASSERT_IMP(lbl, ante, cons, msg)
`define RSP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/rsp_pkg.sv =====
package rsp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CELL_W    = 16;
  localparam int POS_W     = 32;
  localparam int VEC_W     = 18;
  localparam int SCR_W     = 13;
  localparam int HW_W      = SCR_W - 1;
  localparam int SW        = CELL_W + FRAC_BITS + 2;  // sprite offset from camera
  localparam int DPW       = 2 * VEC_W;               // det partial products
  localparam int DETW      = DPW + 1;
  localparam int PW        = SW + VEC_W;              // offset * vector products
  localparam int NW        = PW + 1;                  // nx, ny
  localparam int SWD       = NW + 1;                  // nx + ny
  localparam int PC_W      = HW_W + SWD;
  localparam int PS_W      = SCR_W + DETW;
  localparam int REMW      = 72;
  localparam int DQ_BITS   = 31;
  localparam int CQ_BITS   = 17;
  localparam int SQ_BITS   = 16;
  localparam int DEPTH_W   = 32;
  localparam int COL_W     = 17;
  localparam int SIZE_W    = 16;

  typedef enum logic [2:0] {
    REG_POS_X,
    REG_POS_Y,
    REG_DIR_X,
    REG_DIR_Y,
    REG_PLANE_X,
    REG_PLANE_Y,
    REG_WIDTH,
    REG_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [VEC_W-1:0] dir_x;
    logic [VEC_W-1:0] dir_y;
    logic [VEC_W-1:0] plane_x;
    logic [VEC_W-1:0] plane_y;
    logic [SCR_W-1:0] width;
    logic [SCR_W-1:0] height;
  } cam_cfg_t;

  typedef struct packed {
    logic            degen;
    logic            neg_depth;
    logic            neg_col;
    logic [NW-1:0]   ny_mag;
    logic [SWD-1:0]  s_mag;
    logic [DETW-1:0] det_mag;
  } front_t;

  typedef struct packed {
    logic               degen;
    logic               neg_depth;
    logic               neg_col;
    logic               ovf_d;
    logic               ovf_c;
    logic               ovf_s;
    logic [NW-1:0]      ny_mag;
    logic [DETW-1:0]    det_mag;
    logic [REMW-1:0]    rem_d;
    logic [REMW-1:0]    rem_c;
    logic [REMW-1:0]    rem_s;
    logic [DQ_BITS-1:0] q_d;
    logic [CQ_BITS-1:0] q_c;
    logic [SQ_BITS-1:0] q_s;
  } div_t;

endpackage

// ===== src/raycast_sprite_projection_top.sv =====
// Sprite projection for a raycaster.
// Input stream: one request per sprite, in_tdata = {cell_y, cell_x}.
// Output stream: one result per request, in order. out_tdata carries
// depth, screen column, size and the clamped draw window; out_tuser is the
// degenerate flag (zero determinant or zero depth; size saturated, depth zero, column at half_w).
// Camera and screen registers are to be written through cfg_we/cfg_addr/cfg_wdata
// while no request is in flight; the user must ensure this, the block does not enforce it.
// From input acceptance to output valid the pipeline has four front
// stages (offset, products, nx/ny/det, magnitudes), one multiply stage,
// one overflow check stage, 31 restoring divider stages (one quotient bit
// per stage for depth, column and size in lock step), a finish stage and
// the output register. A new request is taken every cycle while not stalled.
// When out_tready is low with a result held, the whole pipeline freezes and
// in_tready drops; nothing is dropped or repeated.
// Reset clears all valid bits and loads the default camera (facing +x,
// 640 x 480 screen).
`include "raycast_sprite_projection_top_defines.svh"

module raycast_sprite_projection_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [15:0] sprite_cell_x, [31:16] sprite_cell_y
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] depth, [48:32] screen_col, [64:49] sprite_size, [77:65] start_row,
  // [90:78] end_row, [106:91] start_col, [123:107] end_col, [127:124] zero
  output logic [127:0] out_tdata,
  output logic         out_tuser,  // [0] degenerate
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  localparam int FB      = rsp_pkg::FRAC_BITS;
  localparam int REMW    = rsp_pkg::REMW;
  localparam int DQ      = rsp_pkg::DQ_BITS;
  localparam int CQ      = rsp_pkg::CQ_BITS;
  localparam int SQ      = rsp_pkg::SQ_BITS;
  localparam int HW_W    = rsp_pkg::HW_W;
  localparam int SCR_W   = rsp_pkg::SCR_W;
  localparam int PC_W    = rsp_pkg::PC_W;
  localparam int PS_W    = rsp_pkg::PS_W;
  localparam int DEPTH_W = rsp_pkg::DEPTH_W;
  localparam int COL_W   = rsp_pkg::COL_W;
  localparam int SIZE_W  = rsp_pkg::SIZE_W;
  localparam int VEC_W   = rsp_pkg::VEC_W;
  localparam int POS_W   = rsp_pkg::POS_W;

  localparam logic [DEPTH_W-1:0] DEPTH_POS_SAT = {1'b0, {(DEPTH_W - 1){1'b1}}};
  localparam logic [DEPTH_W-1:0] DEPTH_NEG_SAT = {1'b1, {(DEPTH_W - 1){1'b0}}};
  localparam logic [COL_W-1:0]   COL_LIM       = {1'b1, {(COL_W - 1){1'b0}}};
  localparam logic [COL_W-1:0]   COL_POS_MAX   = {1'b0, {(COL_W - 1){1'b1}}};
  localparam logic [SIZE_W-1:0]  SIZE_SAT      = {SIZE_W{1'b1}};

  // ---------------- configuration ----------------
  rsp_pkg::cam_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_x   <= '0;
      cfg_r.pos_y   <= '0;
      cfg_r.dir_x   <= VEC_W'(65536);
      cfg_r.dir_y   <= '0;
      cfg_r.plane_x <= '0;
      cfg_r.plane_y <= VEC_W'(43254);
      cfg_r.width   <= SCR_W'(640);
      cfg_r.height  <= SCR_W'(480);
    end else if (cfg_we) begin
      unique case (rsp_pkg::cfg_reg_t'(cfg_addr))
        rsp_pkg::REG_POS_X:   cfg_r.pos_x   <= cfg_wdata[POS_W-1:0];
        rsp_pkg::REG_POS_Y:   cfg_r.pos_y   <= cfg_wdata[POS_W-1:0];
        rsp_pkg::REG_DIR_X:   cfg_r.dir_x   <= cfg_wdata[VEC_W-1:0];
        rsp_pkg::REG_DIR_Y:   cfg_r.dir_y   <= cfg_wdata[VEC_W-1:0];
        rsp_pkg::REG_PLANE_X: cfg_r.plane_x <= cfg_wdata[VEC_W-1:0];
        rsp_pkg::REG_PLANE_Y: cfg_r.plane_y <= cfg_wdata[VEC_W-1:0];
        rsp_pkg::REG_WIDTH:   cfg_r.width   <= cfg_wdata[SCR_W-1:0];
        rsp_pkg::REG_HEIGHT:  cfg_r.height  <= cfg_wdata[SCR_W-1:0];
        default:              cfg_r         <= cfg_r;
      endcase
    end
  end

  logic [HW_W-1:0] half_w, half_h;
  assign half_w = cfg_r.width[SCR_W-1:1];
  assign half_h = cfg_r.height[SCR_W-1:1];

  // ---------------- pipeline control ----------------
  logic adv;
  logic out_valid_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // ---------------- front: camera-space transform ----------------
  logic            fr_valid;
  rsp_pkg::front_t fr;

  rsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .cell_x    (in_tdata[15:0]),
    .cell_y    (in_tdata[31:16]),
    .cfg       (cfg_r),
    .out_valid (fr_valid),
    .out_data  (fr)
  );

  // ---------------- dividend products ----------------
  logic            mv_r;
  rsp_pkg::front_t mf_r;
  logic [PC_W-1:0] prod_c_r;
  logic [PS_W-1:0] prod_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (adv) begin
      mv_r <= fr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mf_r     <= fr;
      prod_c_r <= PC_W'(half_w) * fr.s_mag;
      prod_s_r <= PS_W'(cfg_r.height) * fr.det_mag;
    end
  end

  // ---------------- divider setup and overflow checks ----------------
  rsp_pkg::div_t dinit;

  always_comb begin
    dinit.degen     = mf_r.degen;
    dinit.neg_depth = mf_r.neg_depth;
    dinit.neg_col   = mf_r.neg_col;
    dinit.ny_mag    = mf_r.ny_mag;
    dinit.det_mag   = mf_r.det_mag;
    // ny*2^F >= det*2^DQ, reduced by 2^F on both sides
    dinit.ovf_d     = REMW'(mf_r.ny_mag) >= (REMW'(mf_r.det_mag) << (DQ - FB));
    dinit.ovf_c     = REMW'(prod_c_r) >= (REMW'(mf_r.ny_mag) << CQ);
    dinit.ovf_s     = REMW'(prod_s_r) >= (REMW'(mf_r.ny_mag) << SQ);
    dinit.rem_d     = REMW'(mf_r.ny_mag) << FB;
    dinit.rem_c     = REMW'(prod_c_r);
    dinit.rem_s     = REMW'(prod_s_r);
    dinit.q_d       = '0;
    dinit.q_c       = '0;
    dinit.q_s       = '0;
  end

  function automatic rsp_pkg::div_t div_step(input rsp_pkg::div_t x, input int unsigned b);
    rsp_pkg::div_t   y;
    logic [REMW-1:0] dd;
    logic [REMW-1:0] dn;
    y  = x;
    dd = REMW'(x.det_mag) << b;
    dn = REMW'(x.ny_mag) << b;
    if (x.rem_d >= dd) begin
      y.rem_d = x.rem_d - dd;
      y.q_d   = x.q_d | (DQ'(1) << b);
    end
    if ((b < CQ) && (x.rem_c >= dn)) begin
      y.rem_c = x.rem_c - dn;
      y.q_c   = x.q_c | (CQ'(1) << b);
    end
    if ((b < SQ) && (x.rem_s >= dn)) begin
      y.rem_s = x.rem_s - dn;
      y.q_s   = x.q_s | (SQ'(1) << b);
    end
    return y;
  endfunction

  rsp_pkg::div_t dv_r [0:DQ];
  logic          dvv_r [0:DQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvv_r[0] <= 1'b0;
    end else if (adv) begin
      dvv_r[0] <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0] <= dinit;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar j = 0; j < DQ; j++) begin : g_div
    rsp_pkg::div_t step_nxt;

    always_comb begin
      step_nxt = div_step(dv_r[j], (DQ - 1 - j));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvv_r[j+1] <= 1'b0;
      end else if (adv) begin
        dvv_r[j+1] <= dvv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[j+1] <= step_nxt;
      end
    end
  end

  // ---------------- finish: signs, saturation ----------------
  rsp_pkg::div_t      dq;
  logic               fin_v_r;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [COL_W-1:0]   col_r, col_nxt, col_mag;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic               degen_r;

  assign dq = dv_r[DQ];

  always_comb begin
    col_mag = dq.ovf_c ? COL_LIM : ((dq.q_c > COL_LIM) ? COL_LIM : dq.q_c);
    if (dq.degen) begin
      depth_nxt = '0;
      col_nxt   = COL_W'(half_w);
      size_nxt  = SIZE_SAT;
    end else begin
      if (dq.ovf_d) begin
        depth_nxt = dq.neg_depth ? DEPTH_NEG_SAT : DEPTH_POS_SAT;
      end else if (dq.neg_depth) begin
        depth_nxt = DEPTH_W'(0) - {1'b0, dq.q_d};
      end else begin
        depth_nxt = {1'b0, dq.q_d};
      end
      if (dq.neg_col) begin
        col_nxt = COL_W'(0) - col_mag;
      end else begin
        col_nxt = (col_mag > COL_POS_MAX) ? COL_POS_MAX : col_mag;
      end
      size_nxt = dq.ovf_s ? SIZE_SAT : dq.q_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (adv) begin
      fin_v_r <= dvv_r[DQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      depth_r <= depth_nxt;
      col_r   <= col_nxt;
      size_r  <= size_nxt;
      degen_r <= dq.degen;
    end
  end

  // ---------------- draw window ----------------
  logic [SIZE_W-2:0]       half_sz;
  logic signed [COL_W-1:0] srow_d;
  logic [SIZE_W-1:0]       erow_s;
  logic signed [COL_W:0]   scol_d, ecol_s;
  logic signed [COL_W:0]   w_ext;
  logic [SCR_W-1:0]        srow_nxt, erow_nxt;
  logic [SIZE_W-1:0]       scol_nxt;
  logic [COL_W-1:0]        ecol_nxt;

  assign half_sz = size_r[SIZE_W-1:1];
  assign w_ext   = $signed({{(COL_W + 1 - SCR_W){1'b0}}, cfg_r.width});

  always_comb begin
    srow_d   = $signed(COL_W'(half_h)) - $signed(COL_W'(half_sz));
    srow_nxt = srow_d[COL_W-1] ? '0 : srow_d[SCR_W-1:0];
    erow_s   = SIZE_W'(half_sz) + SIZE_W'(half_h);
    erow_nxt = (erow_s >= SIZE_W'(cfg_r.height)) ? cfg_r.height : erow_s[SCR_W-1:0];
    scol_d   = $signed({col_r[COL_W-1], col_r}) - $signed((COL_W + 1)'(half_sz));
    scol_nxt = scol_d[COL_W] ? '0 : scol_d[SIZE_W-1:0];
    ecol_s   = $signed({col_r[COL_W-1], col_r}) + $signed((COL_W + 1)'(half_sz));
    ecol_nxt = (ecol_s >= w_ext) ? COL_W'(cfg_r.width) : ecol_s[COL_W-1:0];
  end

  // ---------------- output register ----------------
  logic [DEPTH_W-1:0] o_depth_r;
  logic [COL_W-1:0]   o_col_r;
  logic [SIZE_W-1:0]  o_size_r;
  logic [SCR_W-1:0]   o_srow_r, o_erow_r;
  logic [SIZE_W-1:0]  o_scol_r;
  logic [COL_W-1:0]   o_ecol_r;
  logic               o_degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_depth_r <= depth_r;
      o_col_r   <= col_r;
      o_size_r  <= size_r;
      o_srow_r  <= srow_nxt;
      o_erow_r  <= erow_nxt;
      o_scol_r  <= scol_nxt;
      o_ecol_r  <= ecol_nxt;
      o_degen_r <= degen_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, o_ecol_r, o_scol_r, o_erow_r, o_srow_r,
                       o_size_r, o_col_r, o_depth_r};
  assign out_tuser  = o_degen_r;

  // ---------------- checks ----------------
  `RSP_ASSERT_IMP(a_degen_size, out_valid_r && o_degen_r, o_size_r == SIZE_SAT, "degenerate result without saturated size")
  `RSP_ASSERT_IMP(a_degen_depth, out_valid_r && o_degen_r, o_depth_r == '0, "degenerate result with nonzero depth")
  `RSP_ASSERT_IMP(a_erow_clamp, out_valid_r, o_erow_r <= cfg_r.height, "end row beyond screen height")
  `RSP_ASSERT_IMP(a_ecol_clamp, out_valid_r, $signed({o_ecol_r[COL_W-1], o_ecol_r}) <= w_ext, "end column beyond screen width")
  `RSP_ASSERT_NXT(a_stall_hold, out_valid_r && !out_tready, out_valid_r && $stable(o_depth_r) && $stable(o_size_r), "stalled result changed")

endmodule

// ===== src/rsp_front.sv =====
module rsp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [15:0]           cell_x,
  input  logic [15:0]           cell_y,
  input  rsp_pkg::cam_cfg_t     cfg,
  output logic                  out_valid,
  output rsp_pkg::front_t       out_data
);

  localparam int SW   = rsp_pkg::SW;
  localparam int DPW  = rsp_pkg::DPW;
  localparam int DETW = rsp_pkg::DETW;
  localparam int PW   = rsp_pkg::PW;
  localparam int NW   = rsp_pkg::NW;
  localparam int SWD  = rsp_pkg::SWD;
  localparam int FB   = rsp_pkg::FRAC_BITS;
  localparam int PX_W = rsp_pkg::POS_W;

  logic v1_r, v2_r, v3_r, v4_r;

  logic signed [SW-1:0]   sx_r, sy_r, sx_nxt, sy_nxt;
  logic signed [DPW-1:0]  pd0_r, pd1_r;
  logic signed [PW-1:0]   p0_r, p1_r, p2_r, p3_r;
  logic signed [DETW-1:0] det2_r, det3_r;
  logic signed [NW-1:0]   nx_r, ny_r;
  rsp_pkg::front_t        fr_r, fr_nxt;

  logic signed [SWD-1:0]  s_sum;

  // cell + 0.5 minus camera position
  always_comb begin
    sx_nxt = $signed({2'b00, cell_x, FB'(1 << (FB - 1))})
           - $signed({{(SW - PX_W){cfg.pos_x[PX_W-1]}}, cfg.pos_x});
    sy_nxt = $signed({2'b00, cell_y, FB'(1 << (FB - 1))})
           - $signed({{(SW - PX_W){cfg.pos_y[PX_W-1]}}, cfg.pos_y});
  end

  always_comb begin
    s_sum = $signed({nx_r[NW-1], nx_r}) + $signed({ny_r[NW-1], ny_r});
    fr_nxt.degen     = (det3_r == '0) || (ny_r == '0);
    fr_nxt.neg_depth = ny_r[NW-1] ^ det3_r[DETW-1];
    fr_nxt.neg_col   = s_sum[SWD-1] ^ ny_r[NW-1];
    fr_nxt.ny_mag    = ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
    fr_nxt.s_mag     = s_sum[SWD-1] ? SWD'(-s_sum) : SWD'(s_sum);
    fr_nxt.det_mag   = det3_r[DETW-1] ? DETW'(-det3_r) : DETW'(det3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      pd0_r  <= $signed(cfg.plane_x) * $signed(cfg.dir_y);
      pd1_r  <= $signed(cfg.plane_y) * $signed(cfg.dir_x);
      p0_r   <= sx_r * $signed(cfg.dir_y);
      p1_r   <= sy_r * $signed(cfg.dir_x);
      p2_r   <= sy_r * $signed(cfg.plane_x);
      p3_r   <= sx_r * $signed(cfg.plane_y);
      det2_r <= DETW'(pd0_r) - DETW'(pd1_r);
      nx_r   <= NW'(p0_r) - NW'(p1_r);
      ny_r   <= NW'(p2_r) - NW'(p3_r);
      det3_r <= det2_r;
      fr_r   <= fr_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = fr_r;

endmodule
